/* hdl/imgrot_pkg.sv */
// ----------------------------------------------------------------------------
// imgrot_pkg
// Shared constants and types of the square image rotator: frame geometry,
// store addressing widths, output queue sizing and the records passed
// between the address controller, the store and the output queue.
// ----------------------------------------------------------------------------
package imgrot_pkg;

  // largest frame side the store holds
  localparam int MAX_SIDE   = 64;

  // width of the image_size register field as seen on the port
  localparam int CFG_W      = 7;

  // bits for a side value up to MAX_SIDE, and for the held register
  localparam int SIZE_W     = $clog2(MAX_SIDE + 1);
  localparam int REG_W      = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;

  // compare width: side values and positions with a spare bit
  localparam int CMP_W      = REG_W + 1;

  // row and column position within a frame
  localparam int POS_W      = $clog2(MAX_SIDE);

  // ping-pong store geometry
  localparam int BANK_WORDS = MAX_SIDE * MAX_SIDE;
  localparam int STORE_DEPTH = 2 * BANK_WORDS;
  localparam int ADDR_W     = $clog2(STORE_DEPTH);

  localparam int PIX_W      = 32;

  // output queue
  localparam int QUEUE_DEPTH = 3;

  // memory access issued by the controller for one request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // flags of a read in flight, aligned with the store read data
  typedef struct packed {
    logic valid;
    logic row_last;
    logic frame_last;
  } emit_meta_t;

  // one finished result held in the output queue
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_last;
    logic             frame_last;
  } out_item_t;

endpackage

/* hdl/imgrot_ifs.sv */
// ----------------------------------------------------------------------------
// imgrot channel interfaces
// Valid/ready channels of the rotator: pixel input, rotated pixel output
// and the frame side configuration write.
// ----------------------------------------------------------------------------
interface imgrot_in_if
  import imgrot_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output mode, output pixel_in, input ready);
  modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface imgrot_out_if
  import imgrot_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             row_last;
  logic             frame_last;

  modport source (output valid, output pixel_out, output row_last, output frame_last,
                  input ready);
  modport sink   (input valid, input pixel_out, input row_last, input frame_last,
                  output ready);
endinterface

interface imgrot_cfg_if
  import imgrot_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] image_size;

  modport source (output valid, output image_size, input ready);
  modport sink   (input valid, input image_size, output ready);
endinterface

/* hdl/imgrot_ram.sv */
// ----------------------------------------------------------------------------
// imgrot_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module imgrot_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/imgrot_addr_ctrl.sv */
// ----------------------------------------------------------------------------
// imgrot_addr_ctrl
// Load and emit position counters, bank select and frame side register.
// Turns each accepted request into one store write (store requests) and
// one store read of the rotated position of the held frame, if one is held.
// ----------------------------------------------------------------------------
module imgrot_addr_ctrl
  import imgrot_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             mode,
  input  logic [PIX_W-1:0] pixel_in,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  output ram_req_t         ram_req,
  output emit_meta_t       meta_r
);

  logic [REG_W-1:0] image_size_r;
  logic [POS_W-1:0] load_row_r, load_row_nxt;
  logic [POS_W-1:0] load_col_r, load_col_nxt;
  logic [POS_W-1:0] emit_row_r, emit_row_nxt;
  logic [POS_W-1:0] emit_col_r, emit_col_nxt;
  logic             load_bank_r, load_bank_nxt;
  logic             frame_ready_r, frame_ready_nxt;
  emit_meta_t       meta_nxt;

  logic [CMP_W-1:0] side_n;
  logic [CMP_W-1:0] side_m1;
  logic [CMP_W-1:0] emit_col_x;
  logic [CMP_W-1:0] emit_row_x;
  logic [CMP_W-1:0] load_col_x;
  logic [CMP_W-1:0] load_row_x;
  logic [POS_W-1:0] src_row;
  logic             emit_go;
  logic             store_go;
  logic             rl;
  logic             fl;
  logic             load_row_end;
  logic             load_frame_end;

  // store address of a bank, row and column
  function automatic logic [ADDR_W-1:0] store_addr(input logic bank,
                                                   input logic [POS_W-1:0] row,
                                                   input logic [POS_W-1:0] col);
    store_addr = ADDR_W'(BANK_WORDS) * ADDR_W'(bank)
               + ADDR_W'(row) * ADDR_W'(MAX_SIDE)
               + ADDR_W'(col);
  endfunction

  // effective side: zero acts as one, clamp at the store size
  always_comb begin
    if (image_size_r == '0) begin
      side_n = CMP_W'(1);
    end else if (CMP_W'(image_size_r) > CMP_W'(MAX_SIDE)) begin
      side_n = CMP_W'(MAX_SIDE);
    end else begin
      side_n = CMP_W'(image_size_r);
    end
    side_m1    = side_n - CMP_W'(1);
    emit_col_x = CMP_W'(emit_col_r);
    emit_row_x = CMP_W'(emit_row_r);
    load_col_x = CMP_W'(load_col_r);
    load_row_x = CMP_W'(load_row_r);
  end

  // store requests: write at the load position, read at the rotated source position
  always_comb begin
    emit_go  = accept && frame_ready_r;
    store_go = accept && !mode;
    if (emit_col_x < side_n) begin
      src_row = POS_W'(side_m1 - emit_col_x);
    end else begin
      src_row = '0;
    end
    rl = emit_col_x >= side_m1;
    fl = rl && (emit_row_x >= side_m1);
    load_row_end   = load_col_x >= side_m1;
    load_frame_end = load_row_end && (load_row_x >= side_m1);

    ram_req.re    = emit_go;
    ram_req.raddr = store_addr(!load_bank_r, src_row, emit_row_r);
    ram_req.we    = store_go;
    ram_req.waddr = store_addr(load_bank_r, load_row_r, load_col_r);
    ram_req.wdata = pixel_in;

    meta_nxt.valid      = emit_go;
    meta_nxt.row_last   = rl;
    meta_nxt.frame_last = fl;
  end

  // counter and bank updates
  always_comb begin
    load_row_nxt    = load_row_r;
    load_col_nxt    = load_col_r;
    emit_row_nxt    = emit_row_r;
    emit_col_nxt    = emit_col_r;
    load_bank_nxt   = load_bank_r;
    frame_ready_nxt = frame_ready_r;

    // emit position advance
    if (emit_go) begin
      if (rl) begin
        emit_col_nxt = '0;
        if (fl) begin
          emit_row_nxt    = '0;
          frame_ready_nxt = 1'b0;
        end else begin
          emit_row_nxt = emit_row_r + POS_W'(1);
        end
      end else begin
        emit_col_nxt = emit_col_r + POS_W'(1);
      end
    end

    // load position advance, bank swap on the last pixel of a frame
    if (store_go) begin
      if (load_row_end) begin
        load_col_nxt = '0;
        if (load_frame_end) begin
          load_row_nxt    = '0;
          load_bank_nxt   = !load_bank_r;
          frame_ready_nxt = 1'b1;
          emit_row_nxt    = '0;
          emit_col_nxt    = '0;
        end else begin
          load_row_nxt = load_row_r + POS_W'(1);
        end
      end else begin
        load_col_nxt = load_col_r + POS_W'(1);
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r  <= REG_W'(MAX_SIDE);
      load_row_r    <= '0;
      load_col_r    <= '0;
      emit_row_r    <= '0;
      emit_col_r    <= '0;
      load_bank_r   <= 1'b0;
      frame_ready_r <= 1'b0;
      meta_r        <= '0;
    end else begin
      if (cfg_we) begin
        image_size_r <= REG_W'(cfg_data);
      end
      load_row_r    <= load_row_nxt;
      load_col_r    <= load_col_nxt;
      emit_row_r    <= emit_row_nxt;
      emit_col_r    <= emit_col_nxt;
      load_bank_r   <= load_bank_nxt;
      frame_ready_r <= frame_ready_nxt;
      meta_r        <= meta_nxt;
    end
  end

endmodule

/* hdl/imgrot_out_queue.sv */
// ----------------------------------------------------------------------------
// imgrot_out_queue
// Small output queue that catches store read data in the cycle after the
// read and presents it on the output channel. Reserves room for a read
// in flight so the input side never waits on the output handshake
// combinationally.
// ----------------------------------------------------------------------------
module imgrot_out_queue
  import imgrot_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  emit_meta_t       meta,
  input  logic [PIX_W-1:0] rdata,
  output logic             space_ok,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  out_item_t          entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push;
  logic               pop;
  out_item_t          push_item;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // push and pop control
  always_comb begin
    out_valid = count_r != '0;
    push      = meta.valid;
    pop       = out_valid && out_ready;
    out_item  = entry_r[rd_ptr_r];
    space_ok  = ({1'b0, count_r} + (CNT_W + 1)'(meta.valid)) < (CNT_W + 1)'(QUEUE_DEPTH);

    push_item.pixel      = rdata;
    push_item.row_last   = meta.row_last;
    push_item.frame_last = meta.frame_last;

    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hdl/square_image_rotate_90.sv */
// ----------------------------------------------------------------------------
// square_image_rotate_90
// Clockwise quarter-turn of a square frame of 32-bit pixels, streamed.
// ----------------------------------------------------------------------------
// Pixels of an N x N frame arrive in row-major order and are written into
// one bank of a two-bank frame store; each request also reads out the next
// pixel, in rotated row-major order, of the previously completed frame while
// one is held, so the output trails the input by one frame. The banks swap on
// the last pixel of a frame. A drain request (mode 1) only reads out. The
// block takes one request per clock while the output queue has room: each
// request costs at most one store write and one store read, and the store's
// two ports run in the same cycle. A result passes through the store read
// register and then a queue entry before it is valid on the output. A
// three-entry output queue keeps the input flowing while the output is
// briefly stalled; the input waits only when the queue and the read in flight
// would fill it. The frame side is set through the configuration channel; the
// user must write it only while idle, which the block itself does not enforce
// (0 acts as 1, values above 64 act as 64). The store needs no initialization
// after reset; the first frame is held once it is complete.
// ----------------------------------------------------------------------------
module square_image_rotate_90
  import imgrot_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  imgrot_in_if.sink    in_ch,
  imgrot_out_if.source out_ch,
  imgrot_cfg_if.sink   cfg_ch
);

  ram_req_t         ram_req;
  emit_meta_t       meta_r;
  logic [PIX_W-1:0] rdata;
  logic             space_ok;
  logic             accept;
  out_item_t        out_item;

  // handshakes
  assign in_ch.ready  = space_ok;
  assign accept       = in_ch.valid && space_ok;
  assign cfg_ch.ready = 1'b1;

  // counters and address generation
  imgrot_addr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .mode     (in_ch.mode),
    .pixel_in (in_ch.pixel_in),
    .cfg_we   (cfg_ch.valid),
    .cfg_data (cfg_ch.image_size),
    .ram_req  (ram_req),
    .meta_r   (meta_r)
  );

  // two-bank frame store
  imgrot_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  // output queue
  imgrot_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .meta      (meta_r),
    .rdata     (rdata),
    .space_ok  (space_ok),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.pixel_out  = out_item.pixel;
  assign out_ch.row_last   = out_item.row_last;
  assign out_ch.frame_last = out_item.frame_last;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// square_image_rotate_90 testbench
// Streams pixel frames into the rotator and checks every rotated pixel and
// its row and frame end flags against a quarter-turn predictor kept in step
// with each accepted request. Covers small directed frames, side changes
// while a frame is loading or draining, a side above range and a long random
// stream under changing backpressure on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import imgrot_pkg::*;

  // request kinds
  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // side register values beyond the legal range
  localparam logic [CFG_W-1:0] SIDE_ZERO      = 7'd0;
  localparam logic [CFG_W-1:0] SIDE_ABOVE_MAX = 7'd127;

  localparam int CLK_HALF_NS    = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int WATCHDOG_NS    = 40_000_000;

  typedef enum {
    SEND_LIGHT_RECV_HEAVY,
    SEND_HEAVY_RECV_LIGHT,
    NO_IDLE
  } idle_profile_t;

  logic clk;
  logic rst_n;

  imgrot_in_if  in_ch ();
  imgrot_out_if out_ch ();
  imgrot_cfg_if cfg_ch ();

  square_image_rotate_90 DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state: both store banks, positions, side register
  logic [PIX_W-1:0] frame_copy [STORE_DEPTH];
  logic [CFG_W-1:0] side_reg;
  logic [POS_W-1:0] wr_row, wr_col, rd_row, rd_col;
  logic             wr_bank;
  logic             frame_held;

  out_item_t rotated_q [$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int sent_count;

  // clock
  always #(CLK_HALF_NS) clk = ~clk;

  // watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("square_image_rotate_90 test failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int effective_side();
    if (side_reg == 0) return 1;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return int'(side_reg);
  endfunction

  function automatic int pixel_index(input logic bank, input int row, input int col);
    return int'(bank) * BANK_WORDS + row * MAX_SIDE + col;
  endfunction

  function automatic void clear_predictor();
    foreach (frame_copy[i]) frame_copy[i] = '0;
    side_reg   = CFG_W'(MAX_SIDE);
    wr_row     = '0;
    wr_col     = '0;
    rd_row     = '0;
    rd_col     = '0;
    wr_bank    = 1'b0;
    frame_held = 1'b0;
  endfunction

  // one accepted request: read out of the held frame, then store
  function automatic void predict_rotation(input logic mode, input logic [PIX_W-1:0] pix);
    int        n;
    int        src_row;
    out_item_t want;
    n = effective_side();
    if (frame_held) begin
      // output column past the side falls back to source row 0
      src_row         = (rd_col < n) ? (n - 1 - int'(rd_col)) : 0;
      want.pixel      = frame_copy[pixel_index(~wr_bank, src_row, int'(rd_row))];
      want.row_last   = (rd_col >= n - 1);
      want.frame_last = want.row_last && (rd_row >= n - 1);
      rotated_q.push_back(want);
      if (want.row_last) begin
        rd_col = '0;
        if (want.frame_last) begin
          rd_row     = '0;
          frame_held = 1'b0;
        end else begin
          rd_row = rd_row + 1'b1;
        end
      end else begin
        rd_col = rd_col + 1'b1;
      end
    end
    if (mode == MODE_STORE) begin
      frame_copy[pixel_index(wr_bank, int'(wr_row), int'(wr_col))] = pix;
      if (wr_col >= n - 1) begin
        wr_col = '0;
        if (wr_row >= n - 1) begin
          // frame complete: swap banks and hold it for read out
          wr_row     = '0;
          wr_bank    = ~wr_bank;
          frame_held = 1'b1;
          rd_row     = '0;
          rd_col     = '0;
        end else begin
          wr_row = wr_row + 1'b1;
        end
      end else begin
        wr_col = wr_col + 1'b1;
      end
    end
  endfunction

  // ---------------------------------------------------------------- channels

  task automatic set_idle(input idle_profile_t profile);
    case (profile)
      SEND_LIGHT_RECV_HEAVY: begin
        send_idle_pct = 36;
        recv_idle_pct = 54;
      end
      SEND_HEAVY_RECV_LIGHT: begin
        send_idle_pct = 54;
        recv_idle_pct = 36;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // one pixel request; valid stays up for back-to-back requests
  task automatic send_pixel(input logic mode, input logic [PIX_W-1:0] pix);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.pixel_in <= pix;
    do @(posedge clk); while (!in_ch.ready);
    predict_rotation(mode, pix);
    sent_count++;
  endtask

  // stop sending and wait until every expected pixel has come out
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // side register write, only while the block is idle
  task automatic write_side(input logic [CFG_W-1:0] value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.image_size <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    side_reg = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // finish the frame being loaded and read out the held one, so a new side
  // only ever reads entries written by frames of that side
  task automatic close_frames();
    while (wr_row != '0 || wr_col != '0) send_pixel(MODE_STORE, $urandom());
    while (frame_held) send_pixel(MODE_DRAIN, $urandom());
  endtask

  // receiver backpressure
  always @(posedge clk) begin
    out_ch.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic log_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, what);
  endtask

  // result check against the oldest expected pixel
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (rotated_q.size() == 0) begin
        log_failure($sformatf("unexpected result pixel=%h row_last=%b frame_last=%b",
                              out_ch.pixel_out, out_ch.row_last, out_ch.frame_last));
      end else begin
        want = rotated_q.pop_front();
        if (out_ch.pixel_out !== want.pixel)
          log_failure($sformatf("pixel_out expected %h got %h",
                                want.pixel, out_ch.pixel_out));
        if (out_ch.row_last !== want.row_last)
          log_failure($sformatf("row_last expected %b got %b",
                                want.row_last, out_ch.row_last));
        if (out_ch.frame_last !== want.frame_last)
          log_failure($sformatf("frame_last expected %b got %b",
                                want.frame_last, out_ch.frame_last));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // 2x2 frames with extreme pixels, read out overlapping the next load
  task automatic test_basic_frames();
    logic [PIX_W-1:0] edge_pix [8];
    edge_pix = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE};
    write_side(7'd2);
    // nothing held yet: no output
    send_pixel(MODE_DRAIN, 32'hDEAD_BEEF);
    for (int i = 0; i < 8; i++) send_pixel(MODE_STORE, edge_pix[i]);
    send_pixel(MODE_DRAIN, 32'hFFFF_FFFF);
  endtask

  // side 0 (acts as 1) set while a 2x2 frame is partly read out
  task automatic test_side_one_mid_emission();
    settle_block();
    write_side(SIDE_ZERO);
    send_pixel(MODE_DRAIN, 32'h0);
    send_pixel(MODE_STORE, $urandom());
    send_pixel(MODE_STORE, $urandom());
    send_pixel(MODE_DRAIN, $urandom());
  endtask

  // load part of a 3x3 frame, then shrink to 2 so the frame ends early
  task automatic test_shrink_mid_frame();
    settle_block();
    write_side(7'd3);
    repeat (4) send_pixel(MODE_STORE, $urandom());
    settle_block();
    write_side(7'd2);
    send_pixel(MODE_STORE, $urandom());
    repeat (4) send_pixel(MODE_DRAIN, $urandom());
  endtask

  // side above range acts as 64: rows must end at column 63; two rows and
  // a bit are loaded, then a shrink to 3 closes a 3x3 frame that is read out
  task automatic test_side_above_max();
    settle_block();
    write_side(SIDE_ABOVE_MAX);
    repeat (2 * MAX_SIDE + 2) send_pixel(MODE_STORE, $urandom());
    settle_block();
    write_side(7'd3);
    send_pixel(MODE_STORE, $urandom());
    repeat (9) send_pixel(MODE_DRAIN, $urandom());
  endtask

  // random stream: side changes at frame boundaries, small frames
  task automatic test_random_stream(input idle_profile_t profile, input int item_goal);
    int               first;
    int               n;
    int               seg_len;
    logic [CFG_W-1:0] next_side;
    set_idle(profile);
    first = sent_count;
    while (sent_count - first < item_goal) begin
      settle_block();
      if ($urandom_range(3) == 0) begin
        close_frames();
        settle_block();
        next_side = CFG_W'($urandom_range(0, 8));
        write_side(next_side);
      end
      n = effective_side();
      seg_len = $urandom_range(1, 2 * n * n + 8);
      if (seg_len > 150) seg_len = 150;
      repeat (seg_len) begin
        send_pixel(($urandom_range(4) == 0) ? MODE_DRAIN : MODE_STORE, $urandom());
      end
    end
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_STORE;
    in_ch.pixel_in    = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.image_size = '0;
    out_ch.ready      = 1'b0;
    fail_count        = 0;
    sent_count        = 0;
    clear_predictor();
    set_idle(SEND_LIGHT_RECV_HEAVY);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_frames();
    test_side_one_mid_emission();
    test_shrink_mid_frame();
    test_side_above_max();
    test_random_stream(SEND_LIGHT_RECV_HEAVY, 520);
    test_random_stream(SEND_HEAVY_RECV_LIGHT, 520);
    test_random_stream(NO_IDLE, 500);
    settle_block();

    if (fail_count == 0 && rotated_q.size() == 0) begin
      $display("square_image_rotate_90 test passed");
    end else begin
      $display("square_image_rotate_90 test failed");
    end
    $finish;
  end

endmodule
